>>> rtl/sbfr_pkg.sv
// Shared types and constants for the SBUS frame receiver.
`timescale 1ns / 1ps

package sbfr_pkg;

	// Input word kinds (s_tuser)
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result kinds (m_tuser)
	localparam logic RK_CHANNEL = 1'b0;
	localparam logic RK_LOST    = 1'b1;

	// Configuration register indexes
	localparam logic CFG_GAP_LIMIT  = 1'b0;
	localparam logic CFG_LOST_LIMIT = 1'b1;

	localparam int CFG_W = 16;

	localparam logic [7:0] SBUS_HDR    = 8'h0F;
	localparam logic [4:0] FRAME_LEN   = 5'd25;
	localparam logic [4:0] STORE_DEPTH = 5'd23;
	localparam int NUM_CH   = 16;
	localparam int CH_W     = 11;
	localparam int CHANS_W  = NUM_CH * CH_W;

	localparam logic [CH_W-1:0] CH_LO = 11'd172;
	localparam logic [CH_W-1:0] CH_HI = 11'd1811;

	// d*65535/1639 = 39*d + d*1614/1639; the fraction goes by reciprocal,
	// exact for every d up to 1639.
	localparam logic [10:0] FRAC_MUL    = 11'd1614;
	localparam logic [21:0] RECIP       = 22'd2620481;
	localparam int          RECIP_SHIFT = 32;

	// One job for the back end: a whole frame or a lost event
	typedef struct packed {
		logic               kind;
		logic [7:0]         flags;
		logic [CHANS_W-1:0] chans;
	} job_t;

endpackage

>>> rtl/sbfr_front.sv
// Front end: byte/tick classification, frame assembly, gap and lost timers.
`timescale 1ns / 1ps

module sbfr_front #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [sbfr_pkg::CFG_W-1:0] cfg_data,
	input  logic                      accept,
	input  logic                      cmd,
	input  logic [7:0]                data_byte,
	output logic                      push,
	output sbfr_pkg::job_t            job
);

	localparam int CMP_W = (COUNTER_WIDTH > sbfr_pkg::CFG_W) ? COUNTER_WIDTH : sbfr_pkg::CFG_W;
	localparam int SHIFT_W = 8 * 23;

	logic [sbfr_pkg::CFG_W-1:0] gap_limit_q, lost_limit_q;
	logic [4:0]                 idx_q;
	logic [COUNTER_WIDTH-1:0]   gap_q, lost_q;
	logic                       avail_q;
	logic [SHIFT_W-1:0]         shift_q;

	logic [COUNTER_WIDTH-1:0] gap_inc, lost_inc;
	logic                     gap_over, lost_over;
	logic [4:0]               idx_start, idx_next;
	logic                     store_byte, frame_done, lost_evt;

	assign gap_inc  = (gap_q == '1) ? gap_q : gap_q + 1'b1;
	assign lost_inc = (lost_q == '1) ? lost_q : lost_q + 1'b1;
	assign gap_over  = CMP_W'(gap_q) > CMP_W'(gap_limit_q);
	assign lost_over = CMP_W'(lost_inc) > CMP_W'(lost_limit_q);

	always_comb begin
		idx_start = (gap_over || idx_q >= sbfr_pkg::FRAME_LEN) ? 5'd0 : idx_q;
		store_byte = 1'b0;
		if (idx_start == 5'd0) begin
			idx_next = (data_byte == sbfr_pkg::SBUS_HDR) ? 5'd1 : 5'd0;
		end else begin
			store_byte = idx_start <= sbfr_pkg::STORE_DEPTH;
			idx_next = idx_start + 5'd1;
		end
	end

	assign frame_done = accept && cmd == sbfr_pkg::CMD_BYTE && idx_next == sbfr_pkg::FRAME_LEN;
	assign lost_evt   = accept && cmd == sbfr_pkg::CMD_TICK && avail_q && lost_over;
	assign push       = frame_done || lost_evt;

	always_comb begin
		job = '0;
		if (frame_done) begin
			job.kind  = sbfr_pkg::RK_CHANNEL;
			// footer is not stored, so the newest byte held is the flag byte
			job.flags = shift_q[SHIFT_W-1 -: 8];
			job.chans = shift_q[sbfr_pkg::CHANS_W-1:0];
		end else begin
			job.kind = sbfr_pkg::RK_LOST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q  <= 16'd2;
			lost_limit_q <= 16'd100;
			idx_q        <= '0;
			gap_q        <= '0;
			lost_q       <= '0;
			avail_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sbfr_pkg::CFG_GAP_LIMIT:  gap_limit_q  <= cfg_data;
					sbfr_pkg::CFG_LOST_LIMIT: lost_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (cmd == sbfr_pkg::CMD_TICK) begin
					gap_q  <= gap_inc;
					lost_q <= lost_inc;
					if (lost_evt)
						avail_q <= 1'b0;
				end else begin
					gap_q <= '0;
					if (frame_done) begin
						idx_q   <= '0;
						lost_q  <= '0;
						avail_q <= 1'b1;
					end else begin
						idx_q <= idx_next;
					end
				end
			end
		end
	end

	// byte 1 ends up in the lowest bits once all 23 stored bytes are in
	always_ff @(posedge clk) begin
		if (accept && cmd == sbfr_pkg::CMD_BYTE && store_byte)
			shift_q <= {data_byte, shift_q[SHIFT_W-1:8]};
	end

endmodule

>>> rtl/sbfr_queue.sv
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps

module sbfr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbfr_pkg::job_t wr_job,
	input  logic           pop,
	output sbfr_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbfr_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> rtl/sbfr_back.sv
// Back end: per-channel sequencer, scaling pipeline and output register.
`timescale 1ns / 1ps

module sbfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sbfr_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,
	output logic           m_tuser,
	output logic           m_tlast
);

	typedef struct packed {
		logic                      kind;
		logic [3:0]                ch;
		logic [sbfr_pkg::CH_W-1:0] val;
		logic [3:0]                flags;
		logic                      link;
		logic                      last;
	} meta_t;

	logic                         en;
	logic                         busy_q, kind_q;
	logic [sbfr_pkg::CHANS_W-1:0] frame_q;
	logic [3:0]                   flags_q, ch_q;
	logic                         busy_n;

	logic        v_s1, v_s2, v_s3, m_tvalid_q;
	meta_t       meta_s1, meta_s2, meta_s3;
	logic [sbfr_pkg::CH_W-1:0] d_s2;
	logic [21:0] t_s2;
	logic [43:0] prod_s3;
	logic [16:0] d39_s3;
	logic [39:0] tdata_q;
	logic        tuser_q, tlast_q;

	logic [sbfr_pkg::CH_W-1:0] clamped, d;
	logic [16:0]               scaled_sum;

	// whole pipe holds while a result waits at the output
	assign en  = !m_tvalid_q || m_tready;
	assign pop = en && !busy_q && !empty;

	always_comb begin
		busy_n = busy_q;
		if (busy_q) begin
			if (kind_q == sbfr_pkg::RK_LOST || ch_q == 4'd15)
				busy_n = 1'b0;
		end else if (!empty) begin
			busy_n = 1'b1;
		end
	end

	always_comb begin
		clamped = meta_s1.val;
		if (clamped < sbfr_pkg::CH_LO)
			clamped = sbfr_pkg::CH_LO;
		if (clamped > sbfr_pkg::CH_HI)
			clamped = sbfr_pkg::CH_HI;
		d = clamped - sbfr_pkg::CH_LO;
	end

	assign scaled_sum = d39_s3 + 17'(prod_s3[43:sbfr_pkg::RECIP_SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			busy_q     <= busy_n;
			v_s1       <= busy_q;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			m_tvalid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (busy_q) begin
				frame_q <= frame_q >> sbfr_pkg::CH_W;
				ch_q    <= ch_q + 4'd1;
			end else if (!empty) begin
				frame_q <= head.chans;
				flags_q <= head.flags[3:0];
				kind_q  <= head.kind;
				ch_q    <= '0;
			end

			// lost jobs carry zero data, so every field but kind and last is zero
			meta_s1.kind  <= kind_q;
			meta_s1.ch    <= ch_q;
			meta_s1.val   <= frame_q[sbfr_pkg::CH_W-1:0];
			meta_s1.flags <= flags_q;
			meta_s1.link  <= kind_q == sbfr_pkg::RK_CHANNEL && !flags_q[3];
			meta_s1.last  <= kind_q == sbfr_pkg::RK_LOST || ch_q == 4'd15;

			meta_s2 <= meta_s1;
			d_s2    <= d;
			t_s2    <= 22'(d) * 22'(sbfr_pkg::FRAC_MUL);

			meta_s3 <= meta_s2;
			prod_s3 <= 44'(t_s2) * 44'(sbfr_pkg::RECIP);
			// 39*d as 40*d - d
			d39_s3  <= 17'({d_s2, 5'b0}) + 17'({d_s2, 3'b0}) - 17'(d_s2);

			tdata_q <= {4'b0, meta_s3.link, meta_s3.flags, scaled_sum[15:0],
				meta_s3.val, meta_s3.ch};
			tuser_q <= meta_s3.kind;
			tlast_q <= meta_s3.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

>>> rtl/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser: cmd; tdata: data_byte
//  m_*      out  m_tvalid/m_tready    tuser: result_kind; tlast: last; tdata: channel fields
//  cfg_*    in   cfg_we               cfg_index 0 gap_limit, 1 lost_limit; cfg_data
//
// One input word per cycle; s_tready drops only while the two-entry job queue is full.
// A frame gives 16 result words, one per cycle while m_tready stays high; the job passes
// the queue, the sequencer registers, stages s1 to s3 and the output register first.
// A lost event gives one word along the same path.
// m_tready low freezes the back end; the front keeps taking words until the queue fills.
// arst_n clears control state and sets gap_limit 2, lost_limit 100.
`timescale 1ns / 1ps

module sbus_frame_receiver #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] channel_index, [14:4] channel_value, [30:15] scaled_value, [31] aux_ch17,
	// [32] aux_ch18, [33] frame_lost, [34] failsafe, [35] link_ok, [39:36] zero
	output logic [39:0] m_tdata,
	output logic        m_tuser,   // [0] result_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	sbfr_pkg::job_t wr_job, rd_job;
	logic           push, pop, full, empty, accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	sbfr_front #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cmd       (s_tuser),
		.data_byte (s_tdata),
		.push      (push),
		.job       (wr_job)
	);

	sbfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (full),
		.empty  (empty)
	);

	sbfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (rd_job),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> tb/sv/tb_sbus_frame_receiver.sv
// Self-checking testbench for the SBUS frame receiver: random byte/tick streams against a predictor.
`timescale 1ns / 1ps

module tb_sbus_frame_receiver;

	localparam int CNT_W      = 16;
	localparam int FULL_SCALE = 65535;

	typedef struct packed {
		logic        kind;
		logic [3:0]  index;
		logic [10:0] raw;
		logic [15:0] scaled;
		logic        aux17;
		logic        aux18;
		logic        lost_flag;
		logic        fs;
		logic        link_ok;
		logic [3:0]  pad;
		logic        last;
	} sbus_word_t;

	// Tracks the receiver state and holds the result words still to come out
	class sbus_scoreboard;
		logic [15:0]      gap_lim;
		logic [15:0]      lost_lim;
		logic [7:0]       frame_bytes[sbfr_pkg::STORE_DEPTH];
		logic [4:0]       bytes_in;
		logic [CNT_W-1:0] since_byte;
		logic [CNT_W-1:0] since_frame;
		logic             link_up;
		logic             fs_flag;
		sbus_word_t       due_words[$];
		int               mismatches;

		function new();
			gap_lim     = 16'd2;
			lost_lim    = 16'd100;
			bytes_in    = '0;
			since_byte  = '0;
			since_frame = '0;
			link_up     = 1'b0;
			fs_flag     = 1'b0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == sbfr_pkg::CFG_GAP_LIMIT)
				gap_lim = val;
			else
				lost_lim = val;
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		function int scale(int v);
			int c;
			c = v;
			if (c < int'(sbfr_pkg::CH_LO)) c = int'(sbfr_pkg::CH_LO);
			if (c > int'(sbfr_pkg::CH_HI)) c = int'(sbfr_pkg::CH_HI);
			return ((c - int'(sbfr_pkg::CH_LO)) * FULL_SCALE) /
				(int'(sbfr_pkg::CH_HI) - int'(sbfr_pkg::CH_LO));
		endfunction

		function void note_word(logic cmd, logic [7:0] b);
			logic [sbfr_pkg::CHANS_W-1:0] chans;
			logic [7:0]                   flags;
			sbus_word_t                   w;
			int                           ch;
			if (cmd == sbfr_pkg::CMD_TICK) begin
				if (since_byte != '1) since_byte++;
				if (since_frame != '1) since_frame++;
				// lost event only on the falling edge of availability
				if (link_up && since_frame > lost_lim) begin
					link_up = 1'b0;
					w = '0;
					w.kind = sbfr_pkg::RK_LOST;
					w.last = 1'b1;
					due_words.push_back(w);
				end
				return;
			end
			if (since_byte > gap_lim || bytes_in >= sbfr_pkg::FRAME_LEN)
				bytes_in = '0;
			if (bytes_in == 0) begin
				if (b == sbfr_pkg::SBUS_HDR) bytes_in = 5'd1;
			end else begin
				if (bytes_in <= sbfr_pkg::STORE_DEPTH)
					frame_bytes[bytes_in - 1] = b;
				bytes_in++;
			end
			since_byte = '0;
			if (bytes_in == sbfr_pkg::FRAME_LEN) begin
				flags       = frame_bytes[sbfr_pkg::STORE_DEPTH - 1];
				fs_flag     = flags[3];
				link_up     = 1'b1;
				since_frame = '0;
				bytes_in    = '0;
				for (ch = 0; ch < 22; ch++)
					chans[ch*8 +: 8] = frame_bytes[ch];
				for (ch = 0; ch < sbfr_pkg::NUM_CH; ch++) begin
					w           = '0;
					w.kind      = sbfr_pkg::RK_CHANNEL;
					w.index     = ch[3:0];
					w.raw       = chans[ch*sbfr_pkg::CH_W +: sbfr_pkg::CH_W];
					w.scaled    = 16'(scale(int'(w.raw)));
					w.aux17     = flags[0];
					w.aux18     = flags[1];
					w.lost_flag = flags[2];
					w.fs        = flags[3];
					w.link_ok   = link_up && !fs_flag;
					w.last      = (ch == sbfr_pkg::NUM_CH - 1);
					due_words.push_back(w);
				end
			end
		endfunction

		function string show(sbus_word_t w);
			return $sformatf("kind %0d ch %0d raw %0d scaled %0d flags %b link %b pad %h last %b",
				w.kind, w.index, w.raw, w.scaled, {w.fs, w.lost_flag, w.aux18, w.aux17},
				w.link_ok, w.pad, w.last);
		endfunction

		function void check_word(sbus_word_t got);
			sbus_word_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %s", show(got));
				return;
			end
			want = due_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %s\n          actual   %s", show(want), show(got));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready;
	// [3:0] channel_index, [14:4] channel_value, [30:15] scaled_value, [31] aux_ch17,
	// [32] aux_ch18, [33] frame_lost, [34] failsafe, [35] link_ok, [39:36] zero
	logic [39:0] m_tdata;
	logic        m_tuser;   // [0] result_kind
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	sbus_scoreboard sb = new();
	bit quiet = 1'b0;
	int n_sent = 0;

	sbus_frame_receiver #(.COUNTER_WIDTH(CNT_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// sink side: random stall bursts unless quiet
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sbus_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind      = m_tuser;
			got.index     = m_tdata[3:0];
			got.raw       = m_tdata[14:4];
			got.scaled    = m_tdata[30:15];
			got.aux17     = m_tdata[31];
			got.aux18     = m_tdata[32];
			got.lost_flag = m_tdata[33];
			got.fs        = m_tdata[34];
			got.link_ok   = m_tdata[35];
			got.pad       = m_tdata[39:36];
			got.last      = m_tlast;
			sb.check_word(got);
		end
	end

	// valid stays high on return unless an idle burst followed
	task automatic send_word(input logic cmd, input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_word(cmd, b);
		n_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// random bytes, now and then preceded by ticks not over the gap limit
	task automatic send_bytes(input int n);
		int k;
		int top;
		top = (sb.gap_lim < 2) ? int'(sb.gap_lim) : 2;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(0, top)) send_word(sbfr_pkg::CMD_TICK, 8'($urandom));
			send_word(sbfr_pkg::CMD_BYTE, 8'($urandom));
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] gap, input logic [15:0] lost);
		cfg_we    <= 1'b1;
		cfg_index <= sbfr_pkg::CFG_GAP_LIMIT;
		cfg_data  <= gap;
		@(posedge clk);
		sb.set_reg(sbfr_pkg::CFG_GAP_LIMIT, gap);
		cfg_index <= sbfr_pkg::CFG_LOST_LIMIT;
		cfg_data  <= lost;
		@(posedge clk);
		sb.set_reg(sbfr_pkg::CFG_LOST_LIMIT, lost);
		cfg_we <= 1'b0;
	endtask

	// mostly whole frames, with noise, cut-off frames and tick runs between
	task automatic traffic(input int n);
		int stop;
		int top;
		stop = n_sent + n;
		while (n_sent < stop) begin
			case ($urandom_range(0, 11))
				7, 8: begin
					repeat ($urandom_range(1, 4)) send_word(sbfr_pkg::CMD_BYTE, 8'($urandom));
				end
				9: begin
					send_word(sbfr_pkg::CMD_BYTE, sbfr_pkg::SBUS_HDR);
					send_bytes($urandom_range(1, 22));
					if (sb.gap_lim < 30)
						repeat (int'(sb.gap_lim) + 1) send_word(sbfr_pkg::CMD_TICK, 8'($urandom));
				end
				10, 11: begin
					top = (sb.lost_lim < 50) ? int'(sb.lost_lim) + 2 : 50;
					repeat ($urandom_range(1, top)) send_word(sbfr_pkg::CMD_TICK, 8'($urandom));
				end
				default: begin
					send_word(sbfr_pkg::CMD_BYTE, sbfr_pkg::SBUS_HDR);
					send_bytes(24);
				end
			endcase
		end
		drain();
	endtask

	initial begin
		int                           dir_vals[sbfr_pkg::NUM_CH] = '{0, 2047, 171, 172, 173,
			1810, 1811, 1812, 1024, 1, 2046, 991, 500, 1500, 1639, 1983};
		logic [sbfr_pkg::CHANS_W-1:0] chans;
		int                           k;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= sbfr_pkg::CMD_BYTE;
		cfg_we    <= 1'b0;
		cfg_index <= sbfr_pkg::CFG_GAP_LIMIT;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray bytes and a tick while unlocked, then one frame of edge values
		send_word(sbfr_pkg::CMD_BYTE, 8'h00);
		send_word(sbfr_pkg::CMD_BYTE, 8'hFF);
		send_word(sbfr_pkg::CMD_TICK, 8'hFF);
		for (k = 0; k < sbfr_pkg::NUM_CH; k++)
			chans[k*sbfr_pkg::CH_W +: sbfr_pkg::CH_W] = dir_vals[k][sbfr_pkg::CH_W-1:0];
		send_word(sbfr_pkg::CMD_BYTE, sbfr_pkg::SBUS_HDR);
		for (k = 0; k < 22; k++)
			send_word(sbfr_pkg::CMD_BYTE, chans[k*8 +: 8]);
		send_word(sbfr_pkg::CMD_BYTE, 8'h0F);   // all four flags, failsafe set
		send_word(sbfr_pkg::CMD_BYTE, 8'h00);
		drain();

		set_limits(16'd0, 16'd0);
		traffic(80);

		set_limits(16'($urandom_range(1, 6)), 16'($urandom_range(5, 40)));
		traffic(110);

		// limits at full scale: no restart, no lost event until the limit drops
		quiet = 1'b1;
		set_limits(16'hFFFF, 16'hFFFF);
		send_word(sbfr_pkg::CMD_BYTE, sbfr_pkg::SBUS_HDR);
		send_bytes(24);
		send_word(sbfr_pkg::CMD_BYTE, sbfr_pkg::SBUS_HDR);
		send_bytes(10);
		repeat (20) send_word(sbfr_pkg::CMD_TICK, 8'($urandom));
		drain();
		set_limits(16'hFFFF, 16'd3);
		send_word(sbfr_pkg::CMD_TICK, 8'($urandom));
		send_bytes(14);
		drain();

		set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 30)));
		traffic(100);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
